>>> design/cdq_pkg.sv
// Package for the circular deque: word types, command codes, sizing
// constants and the capacity clamp. No dependencies.
`timescale 1ns / 1ps

package cdq_pkg;

    // Sizing
    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CAP_W   = $clog2(DEPTH + 1);
    localparam int CFG_W   = 5;
    localparam int DATA_W  = 32;

    // Command codes
    localparam logic [2:0] CMD_PUSH_HEAD = 3'd0;
    localparam logic [2:0] CMD_PUSH_TAIL = 3'd1;
    localparam logic [2:0] CMD_POP_HEAD  = 3'd2;
    localparam logic [2:0] CMD_POP_TAIL  = 3'd3;
    localparam logic [2:0] CMD_REPORT    = 3'd4;

    // Value shown for head and tail when nothing is stored
    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = '1;

    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [DATA_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic                     accepted;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
    } out_word_t;

    // Slot memory access, one write and two reads per cycle
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr_head;
        logic [IDX_W-1:0]  raddr_tail;
    } ram_req_t;

    // Zero acts as one, anything above DEPTH saturates
    function automatic logic [CAP_W-1:0] clamp_cap(input logic [CFG_W-1:0] v);
        logic [CAP_W-1:0] c;
        begin
            if (v == '0) begin
                c = CAP_W'(1);
            end else if (32'(v) > DEPTH) begin
                c = CAP_W'(DEPTH);
            end else begin
                c = CAP_W'(v);
            end
            return c;
        end
    endfunction

endpackage

>>> design/cdq_ram.sv
// Slot storage for the circular deque: one write port, two registered
// read ports. Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_ram (
    input  logic                          aclk,
    input  cdq_pkg::ram_req_t             req,
    output logic [cdq_pkg::DATA_W-1:0]    rdata_head,
    output logic [cdq_pkg::DATA_W-1:0]    rdata_tail
);

    logic [cdq_pkg::DATA_W-1:0] mem [cdq_pkg::DEPTH];
    logic [cdq_pkg::DATA_W-1:0] rd_head_reg;
    logic [cdq_pkg::DATA_W-1:0] rd_tail_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Read ports return the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rd_head_reg <= mem[req.raddr_head];
            rd_tail_reg <= mem[req.raddr_tail];
        end
    end

    assign rdata_head = rd_head_reg;
    assign rdata_tail = rd_tail_reg;

endmodule

>>> design/cdq_ctrl.sv
// Pointer and occupancy control for the circular deque: decodes the command,
// drives the slot memory and builds the result word. Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  cdq_pkg::in_word_t             s_data,
    input  logic                          cfg_we,
    input  logic [cdq_pkg::CFG_W-1:0]     cfg_wdata,
    output cdq_pkg::ram_req_t             ram_req,
    input  logic [cdq_pkg::DATA_W-1:0]    rdata_head,
    input  logic [cdq_pkg::DATA_W-1:0]    rdata_tail,
    output logic                          resp_valid,
    input  logic                          resp_ready,
    output cdq_pkg::out_word_t            resp_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RESP = 1'b1;

    logic                         state_reg, state_next;
    logic [cdq_pkg::CAP_W-1:0]    cap_reg;
    logic [cdq_pkg::IDX_W-1:0]    head_reg, head_next;
    logic [cdq_pkg::IDX_W-1:0]    tail_reg, tail_next;
    logic [cdq_pkg::CAP_W-1:0]    occ_reg, occ_next;
    logic                         acc_reg, acc_next;
    logic                         fwd_head_reg, fwd_tail_reg;
    logic [cdq_pkg::DATA_W-1:0]   fwd_data_reg;

    logic                         accept;
    logic                         full_now, empty_now;
    logic [cdq_pkg::IDX_W-1:0]    head_up, head_dn, tail_up, tail_dn;
    logic                         wr_en;
    logic [cdq_pkg::IDX_W-1:0]    wr_addr;
    logic [cdq_pkg::CAP_W-1:0]    cap_new;
    logic [cdq_pkg::DATA_W-1:0]   front_raw, rear_raw;
    logic                         empty_after;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign full_now  = (occ_reg >= cap_reg);
    assign empty_now = (occ_reg == '0);

    // Pointer steps, wrapping at the capacity by compare
    always_comb begin
        head_up = ((cdq_pkg::CAP_W'(head_reg) + cdq_pkg::CAP_W'(1)) >= cap_reg)
                  ? '0 : head_reg + cdq_pkg::IDX_W'(1);
        tail_up = ((cdq_pkg::CAP_W'(tail_reg) + cdq_pkg::CAP_W'(1)) >= cap_reg)
                  ? '0 : tail_reg + cdq_pkg::IDX_W'(1);
        head_dn = (head_reg == '0)
                  ? cdq_pkg::IDX_W'(cap_reg - cdq_pkg::CAP_W'(1))
                  : head_reg - cdq_pkg::IDX_W'(1);
        tail_dn = (tail_reg == '0)
                  ? cdq_pkg::IDX_W'(cap_reg - cdq_pkg::CAP_W'(1))
                  : tail_reg - cdq_pkg::IDX_W'(1);
    end

    // Command decode
    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        acc_next  = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = head_dn;
        unique case (s_data.cmd)
            cdq_pkg::CMD_PUSH_HEAD: begin
                if (!full_now) begin
                    head_next = head_dn;
                    wr_en     = 1'b1;
                    wr_addr   = head_dn;
                    occ_next  = occ_reg + cdq_pkg::CAP_W'(1);
                    acc_next  = 1'b1;
                end
            end
            cdq_pkg::CMD_PUSH_TAIL: begin
                if (!full_now) begin
                    tail_next = tail_up;
                    wr_en     = 1'b1;
                    wr_addr   = tail_up;
                    occ_next  = occ_reg + cdq_pkg::CAP_W'(1);
                    acc_next  = 1'b1;
                end
            end
            cdq_pkg::CMD_POP_HEAD: begin
                if (!empty_now) begin
                    head_next = head_up;
                    occ_next  = occ_reg - cdq_pkg::CAP_W'(1);
                    acc_next  = 1'b1;
                end
            end
            cdq_pkg::CMD_POP_TAIL: begin
                if (!empty_now) begin
                    tail_next = tail_dn;
                    occ_next  = occ_reg - cdq_pkg::CAP_W'(1);
                    acc_next  = 1'b1;
                end
            end
            cdq_pkg::CMD_REPORT: begin
                acc_next = 1'b1;
            end
            default: begin
                acc_next = 1'b0;
            end
        endcase
    end

    // Memory request: write the pushed word, read both ends after the update
    always_comb begin
        ram_req.we         = accept && wr_en;
        ram_req.waddr      = wr_addr;
        ram_req.wdata      = $unsigned(s_data.value);
        ram_req.re         = accept;
        ram_req.raddr_head = head_next;
        ram_req.raddr_tail = tail_next;
    end

    assign cap_new = cdq_pkg::clamp_cap(cfg_wdata);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RESP;
            ST_RESP: if (resp_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state; a capacity write empties the deque
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cap_reg   <= cdq_pkg::CAP_W'(cdq_pkg::DEPTH);
            head_reg  <= '0;
            tail_reg  <= cdq_pkg::IDX_W'(cdq_pkg::DEPTH - 1);
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                cap_reg  <= cap_new;
                head_reg <= '0;
                tail_reg <= cdq_pkg::IDX_W'(cap_new - cdq_pkg::CAP_W'(1));
                occ_reg  <= '0;
            end else if (accept) begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                occ_reg  <= occ_next;
            end
        end
    end

    // Forward a pushed word that the read ports saw stale
    always_ff @(posedge aclk) begin
        if (accept) begin
            acc_reg      <= acc_next;
            fwd_head_reg <= wr_en && (wr_addr == head_next);
            fwd_tail_reg <= wr_en && (wr_addr == tail_next);
            fwd_data_reg <= $unsigned(s_data.value);
        end
    end

    // Result word from the updated state
    assign front_raw   = fwd_head_reg ? fwd_data_reg : rdata_head;
    assign rear_raw    = fwd_tail_reg ? fwd_data_reg : rdata_tail;
    assign empty_after = (occ_reg == '0);

    always_comb begin
        resp_valid            = (state_reg == ST_RESP);
        resp_data.accepted    = acc_reg;
        resp_data.front_value = empty_after ? cdq_pkg::EMPTY_VALUE : $signed(front_raw);
        resp_data.rear_value  = empty_after ? cdq_pkg::EMPTY_VALUE : $signed(rear_raw);
        resp_data.is_empty    = empty_after;
        resp_data.is_full     = (occ_reg >= cap_reg);
    end

endmodule

>>> design/circular_deque_unit.sv
// An accepted word passes the registered read of both deque ends from the
// slot memory after the pointer update, then the output register; no new
// word is taken until its result has moved into the output register.
// The output register holds a finished result while the next word is taken.
// Reset (aresetn, synchronous): capacity 16, deque empty, no output word;
// slot contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module circular_deque_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  cdq_pkg::in_word_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output cdq_pkg::out_word_t         m_data,
    input  logic                       cfg_we,
    input  logic [cdq_pkg::CFG_W-1:0]  cfg_wdata
);

    cdq_pkg::ram_req_t           ram_req;
    logic [cdq_pkg::DATA_W-1:0]  rdata_head;
    logic [cdq_pkg::DATA_W-1:0]  rdata_tail;
    logic                        resp_valid;
    logic                        resp_ready;
    cdq_pkg::out_word_t          resp_data;
    logic                        m_valid_reg;
    cdq_pkg::out_word_t          m_data_reg;

    cdq_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .ram_req    (ram_req),
        .rdata_head (rdata_head),
        .rdata_tail (rdata_tail),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp_data  (resp_data)
    );

    cdq_ram u_ram (
        .aclk       (aclk),
        .req        (ram_req),
        .rdata_head (rdata_head),
        .rdata_tail (rdata_tail)
    );

    // Output register
    assign resp_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (resp_ready) begin
            m_valid_reg <= resp_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (resp_valid && resp_ready) begin
            m_data_reg <= resp_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> design/cdq_checker.sv
// Port-level checks on the circular deque result channel, bound to
// circular_deque_unit. Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                m_valid,
    input  logic                m_ready,
    input  cdq_pkg::out_word_t  m_data
);

    // A stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // An empty deque shows -1 at both ends
    a_empty_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_empty |->
            m_data.front_value == cdq_pkg::EMPTY_VALUE &&
            m_data.rear_value == cdq_pkg::EMPTY_VALUE)
        else $error("empty deque reported a stored word");

    // Capacity is at least one, so never empty and full together
    a_not_both: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.is_empty && m_data.is_full))
        else $error("deque reported empty and full at once");

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (.*);
